### rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants and types of the linear blend skinning engine.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int BONE_COUNT = 64;
  localparam int INFLUENCES = 4;
  localparam int ENTRIES    = 12;
  localparam int BONE_W     = 6;
  localparam int RAM_DEPTH  = 1 << BONE_W;
  localparam int WGT_W      = 17;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  typedef logic [BONE_W-1:0] bone_t;
  typedef logic [WGT_W-1:0]  wgt_t;
  typedef logic signed [31:0] word_t;

endpackage

### rtl/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/linear_blend_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Four-bone vertex skinning engine with a per-bone 3x4 Q16.16 matrix store.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat is taken on a rising edge with start high and busy low.
//   busy stays low: the pipeline takes one beat every cycle.
//   in_action = load writes the word on in_vert_x into bone in_bone_0,
//   entry in_bone_1 (row-major, 0..11); it gives no result. A load is
//   visible to a transform taken on the next cycle.
//   in_action = transform blends the four bone matrices by their weights,
//   applies the blend to (x, y, z, 1) and gives one result beat.
//   A result shows on out_* with out_valid high for one cycle, once its
//   transform beat has passed the five-stage pipeline (RAM read, weight
//   products, blend rounding, vertex products, sum and saturation).
//   Throughput is one beat per cycle.
//   Each matrix entry is replicated in four RAMs, one per influence.
//   Reset clears the pipeline valid bits only; matrix contents are kept
//   and are undefined until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module linear_blend_skinning (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_action,
  input  lbs_pkg::word_t       in_vert_x,
  input  lbs_pkg::word_t       in_vert_y,
  input  lbs_pkg::word_t       in_vert_z,
  input  lbs_pkg::bone_t       in_bone_0,
  input  lbs_pkg::bone_t       in_bone_1,
  input  lbs_pkg::bone_t       in_bone_2,
  input  lbs_pkg::bone_t       in_bone_3,
  input  lbs_pkg::wgt_t        in_weight_0,
  input  lbs_pkg::wgt_t        in_weight_1,
  input  lbs_pkg::wgt_t        in_weight_2,
  input  lbs_pkg::wgt_t        in_weight_3,
  output logic                 out_valid,
  output lbs_pkg::word_t       out_x,
  output lbs_pkg::word_t       out_y,
  output lbs_pkg::word_t       out_z,
  output logic                 out_overflow
);

  import lbs_pkg::*;

  localparam int PROD_W  = 50;
  localparam int SUM_W   = 53;
  localparam int BLEND_W = SUM_W - 16;
  localparam int ACC_W   = 58;
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) <<< 15;
  localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(32'sh7fffffff);
  localparam logic signed [ACC_W-1:0] S_MIN = -(ACC_W'(1) <<< 31);

  logic  accept;
  bone_t bone_in [4];
  wgt_t  wgt_in  [4];
  word_t vert_in [3];
  word_t ram_q   [4][ENTRIES];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign bone_in = '{in_bone_0, in_bone_1, in_bone_2, in_bone_3};
  assign wgt_in  = '{in_weight_0, in_weight_1, in_weight_2, in_weight_3};
  assign vert_in = '{in_vert_x, in_vert_y, in_vert_z};

  logic load_we;
  assign load_we = accept && (in_action == ACT_LOAD) &&
                   (32'(in_bone_0) < BONE_COUNT);

  for (genvar i = 0; i < 4; i++) begin : g_inf
    for (genvar e = 0; e < ENTRIES; e++) begin : g_ent
      lbs_ram #(.DEPTH(RAM_DEPTH), .WIDTH(32)) u_ram (
        .clk   (clk),
        .we    (load_we && (32'(in_bone_1) == e)),
        .waddr (in_bone_0),
        .wdata (in_vert_x),
        .raddr (bone_in[i]),
        .rdata (ram_q[i][e])
      );
    end
  end

  // stage 1: RAM read, weights, vertex split
  logic                     v1_r, v1_nxt;
  logic                     en1_r  [4];
  wgt_t                     w1_r   [4];
  logic signed [15:0]       vh1_r  [3];
  logic        [15:0]       vl1_r  [3];

  // stage 2: weight products
  logic                     v2_r;
  logic signed [PROD_W-1:0] prod2_r [4][ENTRIES];
  logic signed [PROD_W-1:0] prod_nxt[4][ENTRIES];
  logic signed [15:0]       vh2_r  [3];
  logic        [15:0]       vl2_r  [3];

  // stage 3: rounded blend
  logic                      v3_r;
  logic signed [BLEND_W-1:0] bl3_r  [ENTRIES];
  logic signed [BLEND_W-1:0] bl_nxt [ENTRIES];
  logic signed [15:0]        vh3_r  [3];
  logic        [15:0]        vl3_r  [3];

  // stage 4: vertex products
  logic                      v4_r;
  logic signed [ACC_W-1:0]   hp4_r  [3][3];
  logic signed [ACC_W-1:0]   lp4_r  [3][3];
  logic signed [ACC_W-1:0]   hp_nxt [3][3];
  logic signed [ACC_W-1:0]   lp_nxt [3][3];
  logic signed [BLEND_W-1:0] t4_r   [3];

  // stage 5: outputs
  logic                      out_valid_r;
  word_t                     res_r  [3];
  word_t                     res_nxt[3];
  logic                      ovf_r, ovf_nxt;

  assign v1_nxt = accept && (in_action == ACT_XFORM);

  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int i = 0; i < 4; i++) begin
      for (int e = 0; e < ENTRIES; e++) begin
        prod_nxt[i][e] = en1_r[i] ?
          PROD_W'($signed({1'b0, w1_r[i]}) * $signed(ram_q[i][e])) : '0;
      end
    end
    for (int e = 0; e < ENTRIES; e++) begin
      s = '0;
      for (int i = 0; i < 4; i++) begin
        s = s + SUM_W'(prod2_r[i][e]);
      end
      s = s + (SUM_W'(1) <<< 15);
      bl_nxt[e] = BLEND_W'(s >>> 16);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        hp_nxt[r][c] = ACC_W'(bl3_r[r*4+c] * vh3_r[c]);
        lp_nxt[r][c] = ACC_W'(bl3_r[r*4+c] * $signed({1'b0, vl3_r[c]}));
      end
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] hi, lo, res;
    ovf_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      hi  = hp4_r[r][0] + hp4_r[r][1] + hp4_r[r][2];
      lo  = lp4_r[r][0] + lp4_r[r][1] + lp4_r[r][2] + RND;
      res = hi + ACC_W'(t4_r[r]) + (lo >>> 16);
      if (res > S_MAX) begin
        res_nxt[r] = 32'sh7fffffff;
        ovf_nxt    = 1'b1;
      end else if (res < S_MIN) begin
        res_nxt[r] = 32'sh80000000;
        ovf_nxt    = 1'b1;
      end else begin
        res_nxt[r] = 32'(res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      en1_r[i] <= (i < INFLUENCES) && (32'(bone_in[i]) < BONE_COUNT);
      w1_r[i]  <= wgt_in[i];
    end
    for (int c = 0; c < 3; c++) begin
      vh1_r[c] <= vert_in[c][31:16];
      vl1_r[c] <= vert_in[c][15:0];
      vh2_r[c] <= vh1_r[c];
      vl2_r[c] <= vl1_r[c];
      vh3_r[c] <= vh2_r[c];
      vl3_r[c] <= vl2_r[c];
    end
    prod2_r <= prod_nxt;
    bl3_r   <= bl_nxt;
    hp4_r   <= hp_nxt;
    lp4_r   <= lp_nxt;
    for (int r = 0; r < 3; r++) begin
      t4_r[r] <= bl3_r[r*4+3];
    end
    res_r <= res_nxt;
    ovf_r <= ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_x        = res_r[0];
  assign out_y        = res_r[1];
  assign out_z        = res_r[2];
  assign out_overflow = ovf_r;

`ifndef SYNTHESIS
  a_xform_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_XFORM) |-> ##5 out_valid)
    else $error("transform beat gave no result");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_LOAD) |-> ##5 !out_valid)
    else $error("load beat gave a result");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
       out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
       out_z == 32'sh7fffffff || out_z == 32'sh80000000))
    else $error("overflow without a saturated coordinate");
`endif

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for linear_blend_skinning. Bone matrices are loaded
// entry by entry. Vertices are skinned only against bones whose matrices are
// fully loaded. A local copy of the matrix store predicts each skinned vertex.
// Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import lbs_pkg::*;

  typedef struct {
    logic   action;
    word_t  vx, vy, vz;
    bone_t  bone [4];
    wgt_t   wgt [4];
  } vtx_beat_t;

  typedef struct {
    word_t x, y, z;
    logic  ovf;
  } skin_res_t;

  logic clk, rst_n, start, busy;
  logic out_valid, out_overflow;
  word_t out_x, out_y, out_z;
  vtx_beat_t cur_beat;

  vtx_beat_t beat_queue [$];
  skin_res_t pending_skins [$];
  word_t     mat_store [BONE_COUNT*ENTRIES];
  logic [ENTRIES-1:0] loaded_mask [BONE_COUNT];
  int        full_bones [$];
  bit        failed;
  bit        stim_done;
  int        burst_left, gap_left;

  linear_blend_skinning u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(cur_beat.action),
    .in_vert_x(cur_beat.vx), .in_vert_y(cur_beat.vy), .in_vert_z(cur_beat.vz),
    .in_bone_0(cur_beat.bone[0]), .in_bone_1(cur_beat.bone[1]),
    .in_bone_2(cur_beat.bone[2]), .in_bone_3(cur_beat.bone[3]),
    .in_weight_0(cur_beat.wgt[0]), .in_weight_1(cur_beat.wgt[1]),
    .in_weight_2(cur_beat.wgt[2]), .in_weight_3(cur_beat.wgt[3]),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint rnd_half(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // apply one accepted beat to the local store; skinned result if transform
  function automatic void skin_vertex(vtx_beat_t b);
    longint blend [ENTRIES];
    longint vh [3], vl [3], hi, lo, res;
    word_t  coord [3];
    skin_res_t r;
    r.ovf = 1'b0;
    if (b.action == ACT_LOAD) begin
      if (int'(b.bone[0]) < BONE_COUNT && int'(b.bone[1]) < ENTRIES)
        mat_store[int'(b.bone[0])*ENTRIES + int'(b.bone[1])] = b.vx;
      return;
    end
    foreach (blend[c]) blend[c] = 0;
    for (int i = 0; i < INFLUENCES && i < 4; i++) begin
      if (int'(b.bone[i]) >= BONE_COUNT) continue;
      for (int c = 0; c < ENTRIES; c++)
        blend[c] += longint'(b.wgt[i]) *
                    longint'(mat_store[int'(b.bone[i])*ENTRIES + c]);
    end
    foreach (blend[c]) blend[c] = rnd_half(blend[c]);
    vl[0] = longint'(b.vx) & 64'hFFFF; vh[0] = longint'(b.vx) >>> 16;
    vl[1] = longint'(b.vy) & 64'hFFFF; vh[1] = longint'(b.vy) >>> 16;
    vl[2] = longint'(b.vz) & 64'hFFFF; vh[2] = longint'(b.vz) >>> 16;
    for (int row = 0; row < 3; row++) begin
      hi = 0; lo = 0;
      for (int c = 0; c < 3; c++) begin
        hi += blend[row*4+c] * vh[c];
        lo += blend[row*4+c] * vl[c];
      end
      res = hi + blend[row*4+3] + rnd_half(lo);
      if (res > 64'sd2147483647) begin res = 64'sd2147483647; r.ovf = 1'b1; end
      if (res < -64'sd2147483648) begin res = -64'sd2147483648; r.ovf = 1'b1; end
      coord[row] = word_t'(res);
    end
    r.x = coord[0]; r.y = coord[1]; r.z = coord[2];
    pending_skins = {pending_skins, r};
  endfunction

  function automatic void add_load(int bone, int idx, word_t val);
    vtx_beat_t b;
    b.action = ACT_LOAD;
    b.vx = val; b.vy = $urandom; b.vz = $urandom;
    b.bone[0] = bone_t'(bone); b.bone[1] = bone_t'(idx);
    b.bone[2] = bone_t'($urandom); b.bone[3] = bone_t'($urandom);
    foreach (b.wgt[i]) b.wgt[i] = wgt_t'($urandom);
    beat_queue = {beat_queue, b};
    if (bone < BONE_COUNT && idx < ENTRIES) begin
      loaded_mask[bone][idx] = 1'b1;
      if (&loaded_mask[bone] && !(bone inside {full_bones}))
        full_bones = {full_bones, bone};
    end
  endfunction

  function automatic void add_xform(word_t x, word_t y, word_t z,
                                    int b0, int b1, int b2, int b3,
                                    int w0, int w1, int w2, int w3);
    vtx_beat_t b;
    b.action = ACT_XFORM;
    b.vx = x; b.vy = y; b.vz = z;
    b.bone[0] = bone_t'(b0); b.bone[1] = bone_t'(b1);
    b.bone[2] = bone_t'(b2); b.bone[3] = bone_t'(b3);
    b.wgt[0] = wgt_t'(w0); b.wgt[1] = wgt_t'(w1);
    b.wgt[2] = wgt_t'(w2); b.wgt[3] = wgt_t'(w3);
    beat_queue = {beat_queue, b};
  endfunction

  function automatic word_t rnd_entry();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return word_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic word_t rnd_coord();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      1, 2: return $urandom;
      default: return word_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic int rnd_weight();
    case ($urandom_range(0, 9))
      0: return $urandom_range(65537, 131071);
      1: return $urandom_range(0, 1) ? 65536 : 0;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic int pick_full();
    return full_bones[$urandom_range(0, full_bones.size()-1)];
  endfunction

  initial begin
    int issued, sel;
    foreach (loaded_mask[i]) loaded_mask[i] = '0;
    foreach (mat_store[i]) mat_store[i] = '0;
    // directed: extreme matrix on the top bone, ignored loads, extreme vertices
    for (int e = 0; e < ENTRIES; e++)
      add_load(BONE_COUNT-1, e, (e % 2) ? 32'h80000000 : 32'h7FFFFFFF);
    add_load(0, 12, 32'h12345678);
    add_load(5, 63, 32'hDEADBEEF);
    add_xform(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 63, 63, 63, 63,
              65536, 0, 0, 0);
    add_xform(32'h80000000, 32'h80000000, 32'h80000000, 63, 63, 63, 63,
              131071, 131071, 131071, 131071);
    add_xform(0, 0, 0, 63, 63, 63, 63, 0, 0, 0, 0);
    add_xform(32'h00010000, 32'hFFFF0000, 32'h0000FFFF, 63, 63, 63, 63,
              1, 0, 0, 0);
    add_xform(32'h00008000, 32'h00008000, 32'h00008000, 63, 63, 63, 63,
              32768, 32768, 0, 65536);
    // random: mostly full matrix loads followed by transforms, some noise
    issued = beat_queue.size();
    while (issued < 1600) begin
      sel = $urandom_range(0, 9);
      if (full_bones.size() < 4 || sel < 2) begin
        sel = (full_bones.size() < BONE_COUNT && $urandom_range(0, 1))
              ? $urandom_range(0, BONE_COUNT-1) : $urandom_range(0, BONE_COUNT-1);
        for (int e = 0; e < ENTRIES; e++) add_load(sel, e, rnd_entry());
        issued += ENTRIES;
      end else if (sel == 2) begin
        add_load($urandom_range(0, 63), $urandom_range(0, 63), rnd_entry());
        issued++;
      end else begin
        add_xform(rnd_coord(), rnd_coord(), rnd_coord(),
                  pick_full(), pick_full(), pick_full(), pick_full(),
                  rnd_weight(), rnd_weight(), rnd_weight(), rnd_weight());
        issued++;
      end
    end
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    logic nxt_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) skin_vertex(cur_beat);
      if (!start || !busy) begin
        nxt_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (beat_queue.size() > 0) begin
          cur_beat <= beat_queue.pop_front();
          nxt_start = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
          end
        end
      end
      start <= nxt_start;
    end
  end

  // monitor
  always @(posedge clk) begin
    skin_res_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_skins.size() == 0) begin
        $error("unexpected result beat x=%h y=%h z=%h", out_x, out_y, out_z);
        failed = 1'b1;
      end else begin
        exp_r = pending_skins.pop_front();
        if (out_x !== exp_r.x) begin
          $error("out_x exp %h got %h", exp_r.x, out_x); failed = 1'b1;
        end
        if (out_y !== exp_r.y) begin
          $error("out_y exp %h got %h", exp_r.y, out_y); failed = 1'b1;
        end
        if (out_z !== exp_r.z) begin
          $error("out_z exp %h got %h", exp_r.z, out_z); failed = 1'b1;
        end
        if (out_overflow !== exp_r.ovf) begin
          $error("out_overflow exp %b got %b", exp_r.ovf, out_overflow);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    failed = 1'b0;
    burst_left = 1;
    gap_left = 0;
    start = 1'b0;
    cur_beat = '{action: ACT_LOAD, vx: '0, vy: '0, vz: '0,
                 bone: '{default: '0}, wgt: '{default: '0}};
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (beat_queue.size() > 0 || start || pending_skins.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_skins.size() > 0) failed = 1'b1;
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
